// File: rtl/core/four_class_priority_call_scheduler_defines.svh
// assertion macros for the four class priority call scheduler
// used by the top level only, needs no other file
`ifndef FOUR_CLASS_PRIORITY_CALL_SCHEDULER_DEFINES_SVH
`define FOUR_CLASS_PRIORITY_CALL_SCHEDULER_DEFINES_SVH
`ifndef SYNTHESIS
// plain property check, off during reset
`define FCPCS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("fcpcs assertion failed");
// same-cycle implication
`define FCPCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("fcpcs implication failed");
// next-cycle implication
`define FCPCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("fcpcs next-cycle implication failed");
`else
`define FCPCS_ASSERT(lbl, clk, rstn, prop)
`define FCPCS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define FCPCS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/core/fcpcs_pkg.sv
// shared types and constants of the four class priority call scheduler
// no dependencies
package fcpcs_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int NUM_CLASSES_DEF = 4;

    localparam int ID_W   = 16;
    localparam int DUR_W  = 16;
    localparam int CLS_W  = 2;
    localparam int ENTRY_W = ID_W + DUR_W;

    // action codes carried in tuser
    localparam logic ACT_ARRIVE = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // input tdata, lowest field in the lowest bits
    typedef struct packed {
        logic [5:0]       pad;
        logic [DUR_W-1:0] call_duration;
        logic [ID_W-1:0]  caller_id;
        logic [CLS_W-1:0] caller_class;
    } t_in_data;

    // output tdata, lowest field in the lowest bits
    typedef struct packed {
        logic             pad;
        logic             all_empty;
        logic             line_busy;
        logic [CLS_W-1:0] answered_class;
        logic [ID_W-1:0]  answered_id;
        logic             answered;
        logic             dropped;
        logic             accepted;
    } t_out_data;

    // queue control requests
    typedef struct packed {
        logic enq;
        logic pop;
    } t_qctl_ctl;

    // queue control status
    typedef struct packed {
        logic pick_valid;
        logic enq_full;
        logic all_empty;
    } t_qctl_sts;

endpackage

// File: rtl/core/fcpcs_store.sv
// waiting caller store: one write port, one registered read port
// no package dependency
module fcpcs_store #(
    parameter int AW = 6,
    parameter int DW = 32
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [2**AW];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/fcpcs_qctl.sv
// per-class head, tail and count registers with the priority pick
// depends on fcpcs_pkg
module fcpcs_qctl #(
    parameter int QUEUE_DEPTH = fcpcs_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_CLASSES = fcpcs_pkg::NUM_CLASSES_DEF,
    parameter int PW = $clog2(QUEUE_DEPTH),
    parameter int CW = $clog2(NUM_CLASSES)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  fcpcs_pkg::t_qctl_ctl  i_ctl,
    input  logic [CW-1:0]         i_enq_cls,
    output fcpcs_pkg::t_qctl_sts  o_sts,
    output logic [CW-1:0]         o_pick_cls,
    output logic [PW-1:0]         o_head_ptr,
    output logic [PW-1:0]         o_tail_ptr
);

    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT  = NW'(QUEUE_DEPTH);

    logic [PW-1:0] r_head [NUM_CLASSES];
    logic [PW-1:0] r_tail [NUM_CLASSES];
    logic [NW-1:0] r_cnt  [NUM_CLASSES];

    logic [CW-1:0] pick_cls;
    logic          pick_valid;
    logic          all_empty;

    // lowest-numbered nonempty class wins
    always_comb begin
        pick_cls   = '0;
        pick_valid = 1'b0;
        all_empty  = 1'b1;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if (r_cnt[c] != '0) begin
                pick_cls   = CW'(c);
                pick_valid = 1'b1;
                all_empty  = 1'b0;
            end
        end
    end

    assign o_pick_cls       = pick_cls;
    assign o_head_ptr       = r_head[pick_cls];
    assign o_tail_ptr       = r_tail[i_enq_cls];
    assign o_sts.pick_valid = pick_valid;
    assign o_sts.enq_full   = (r_cnt[i_enq_cls] >= FULL_CNT);
    assign o_sts.all_empty  = all_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_head[c] <= '0;
                r_tail[c] <= '0;
                r_cnt[c]  <= '0;
            end
        end else begin
            if (i_ctl.enq) begin
                r_tail[i_enq_cls] <= (r_tail[i_enq_cls] == LAST_SLOT) ? '0
                                   : r_tail[i_enq_cls] + 1'b1;
                r_cnt[i_enq_cls]  <= r_cnt[i_enq_cls] + 1'b1;
            end
            if (i_ctl.pop) begin
                r_head[pick_cls] <= (r_head[pick_cls] == LAST_SLOT) ? '0
                                  : r_head[pick_cls] + 1'b1;
                r_cnt[pick_cls]  <= r_cnt[pick_cls] - 1'b1;
            end
        end
    end

endmodule

// File: rtl/core/four_class_priority_call_scheduler.sv
// channel   | dir | payload (low bits first)                          | handshake
// s_axis    | in  | tdata: class, id, duration; tuser: action         | tvalid/tready
// m_axis    | out | tdata: accepted, dropped, answered, id, class,    | tvalid/tready
//           |     |        line_busy, all_empty                       |
// an arrival or a tick with nothing to answer writes the result register directly; a tick
// that answers first reads the waiting store in S_READ and then writes the result register
// reset is synchronous and clears pointers, counts and the busy counter;
// the waiting store is not cleared
// a new request is taken while no store read is outstanding and the result register is
// empty or being drained, so a stalled output holds the input back by at most one result
// top level of the four class priority call scheduler
// depends on fcpcs_pkg, fcpcs_qctl, fcpcs_store and the defines header
`include "four_class_priority_call_scheduler_defines.svh"

module four_class_priority_call_scheduler #(
    parameter int QUEUE_DEPTH = fcpcs_pkg::QUEUE_DEPTH_DEF,
    parameter int NUM_CLASSES = fcpcs_pkg::NUM_CLASSES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [1:0] caller_class, [17:2] caller_id, [33:18] call_duration, [39:34] zero
    input  logic [39:0] s_axis_tdata,
    // [0] action
    input  logic [0:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] accepted, [1] dropped, [2] answered, [18:3] answered_id,
    // [20:19] answered_class, [21] line_busy, [22] all_empty, [23] zero
    output logic [23:0] m_axis_tdata
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(NUM_CLASSES);
    localparam int AW = CW + PW;
    localparam int DUR_W = fcpcs_pkg::DUR_W;
    localparam int ENTRY_W = fcpcs_pkg::ENTRY_W;

    typedef enum logic {S_IDLE, S_READ} t_state;

    t_state                r_state;
    logic                  r_out_valid;
    fcpcs_pkg::t_out_data  r_out_data;
    logic [DUR_W-1:0]      r_busy;
    logic [CW-1:0]         r_sel_cls;

    fcpcs_pkg::t_in_data   in_data;
    fcpcs_pkg::t_out_data  n_out_now;
    fcpcs_pkg::t_out_data  n_out_read;
    fcpcs_pkg::t_qctl_ctl  qctl_ctl;
    fcpcs_pkg::t_qctl_sts  qctl_sts;

    logic                  in_fire;
    logic                  out_fire;
    logic                  n_out_valid;
    logic                  is_tick;
    logic [DUR_W-1:0]      busy_dec;
    logic                  do_enq;
    logic                  do_pop;
    logic [CW-1:0]         enq_cls;
    logic [CW-1:0]         pick_cls;
    logic [PW-1:0]         head_ptr;
    logic [PW-1:0]         tail_ptr;
    logic [ENTRY_W-1:0]    rd_entry;

    assign in_data  = fcpcs_pkg::t_in_data'(s_axis_tdata);
    assign is_tick  = (s_axis_tuser[0] == fcpcs_pkg::ACT_TICK);
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // one request at a time; wait while an answering tick reads the store
    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);

    // classes beyond the last one fold into the catch-all class
    assign enq_cls = ({30'd0, in_data.caller_class} >= NUM_CLASSES)
                   ? CW'(NUM_CLASSES - 1) : CW'(in_data.caller_class);

    // saturating decrement of the busy counter
    assign busy_dec = (r_busy != '0) ? r_busy - 1'b1 : '0;

    assign do_enq = in_fire && !is_tick && !qctl_sts.enq_full;
    assign do_pop = in_fire && is_tick && (busy_dec == '0) && qctl_sts.pick_valid;

    assign qctl_ctl.enq = do_enq;
    assign qctl_ctl.pop = do_pop;

    fcpcs_qctl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .NUM_CLASSES (NUM_CLASSES),
        .PW          (PW),
        .CW          (CW)
    ) u_qctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (qctl_ctl),
        .i_enq_cls  (enq_cls),
        .o_sts      (qctl_sts),
        .o_pick_cls (pick_cls),
        .o_head_ptr (head_ptr),
        .o_tail_ptr (tail_ptr)
    );

    // entry layout: id in the upper half, duration in the lower half
    fcpcs_store #(
        .AW (AW),
        .DW (ENTRY_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_enq),
        .i_waddr ({enq_cls, tail_ptr}),
        .i_wdata ({in_data.caller_id, in_data.call_duration}),
        .i_re    (do_pop),
        .i_raddr ({pick_cls, head_ptr}),
        .o_rdata (rd_entry)
    );

    // result of an arrival or of a tick that answers nobody
    always_comb begin
        n_out_now                = '0;
        n_out_now.accepted       = do_enq;
        n_out_now.dropped        = !is_tick && qctl_sts.enq_full;
        n_out_now.line_busy      = is_tick ? (busy_dec != '0) : (r_busy != '0);
        n_out_now.all_empty      = do_enq ? 1'b0 : qctl_sts.all_empty;
    end

    // result of an answering tick, once the store data is back
    always_comb begin
        n_out_read                = '0;
        n_out_read.answered       = 1'b1;
        n_out_read.answered_id    = rd_entry[ENTRY_W-1:DUR_W];
        n_out_read.answered_class = 2'(r_sel_cls);
        n_out_read.line_busy      = (rd_entry[DUR_W-1:0] != '0);
        n_out_read.all_empty      = qctl_sts.all_empty;
    end

    // result register: emptied when drained, filled by a finished request
    always_comb begin
        n_out_valid = r_out_valid && !out_fire;
        if (r_state == S_READ) begin
            n_out_valid = 1'b1;
        end else if (in_fire && !do_pop) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_busy      <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (do_pop) begin
                            r_sel_cls <= pick_cls;
                            r_state   <= S_READ;
                        end else begin
                            r_out_data  <= n_out_now;
                            if (is_tick) begin
                                r_busy <= busy_dec;
                            end
                        end
                    end
                end
                S_READ: begin
                    // answered caller's duration reloads the busy counter
                    r_busy      <= rd_entry[DUR_W-1:0];
                    r_out_data  <= n_out_read;
                    r_state     <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // no request is taken while a store read is outstanding
    `FCPCS_ASSERT_IMP(a_no_accept_in_read, i_clk, i_rst_n, r_state == S_READ, !s_axis_tready)
    // an answering tick always enters the store read state on the next edge
    `FCPCS_ASSERT_NXT(a_pop_then_answer, i_clk, i_rst_n, do_pop, r_state == S_READ)
    // a result never both enqueues and answers
    `FCPCS_ASSERT_IMP(a_one_kind, i_clk, i_rst_n, m_axis_tvalid, !(m_axis_tdata[0] && m_axis_tdata[2]))

endmodule

// File: verif/fcpcs_outcome_checker.sv
// outcome checker for the four class priority call scheduler: watches both stream channels,
// predicts every result from its own copy of the class queues and busy counter, and compares
// depends on fcpcs_pkg only
`timescale 1ns / 1ps

module fcpcs_outcome_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,
    input  logic [0:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_request_count,
    output int          o_result_count,
    output int          o_answer_count,
    output int          o_drop_count,
    output logic        o_model_idle
);

    localparam int DEPTH   = fcpcs_pkg::QUEUE_DEPTH_DEF;
    localparam int CLASSES = fcpcs_pkg::NUM_CLASSES_DEF;
    localparam int ENTRY_W = fcpcs_pkg::ENTRY_W;
    localparam int DUR_W   = fcpcs_pkg::DUR_W;
    localparam int CLS_W   = fcpcs_pkg::CLS_W;

    // waiting callers per class, id above duration
    logic [ENTRY_W-1:0] waiting_calls [CLASSES][DEPTH];
    int unsigned        head_at [CLASSES];
    int unsigned        tail_at [CLASSES];
    int unsigned        held [CLASSES];
    logic [DUR_W-1:0]   busy_ticks;

    fcpcs_pkg::t_out_data pending_outcomes [$];

    function automatic logic queues_clear();
        int c;
        for (c = 0; c < CLASSES; c++) begin
            if (held[c] != 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    // applies one request to the model and returns the result it should produce
    function automatic fcpcs_pkg::t_out_data serve_request(logic act,
                                                           fcpcs_pkg::t_in_data req);
        fcpcs_pkg::t_out_data res;
        int                   cls;
        int                   c;
        logic                 found;
        logic [ENTRY_W-1:0]   entry;
        res   = '0;
        found = 1'b0;
        if (act == fcpcs_pkg::ACT_ARRIVE) begin
            cls = int'(req.caller_class);
            if (cls >= CLASSES) cls = CLASSES - 1;
            if (held[cls] >= DEPTH) begin
                res.dropped = 1'b1;
            end else begin
                waiting_calls[cls][tail_at[cls]] = {req.caller_id, req.call_duration};
                tail_at[cls] = (tail_at[cls] + 1) % DEPTH;
                held[cls]++;
                res.accepted = 1'b1;
            end
        end else begin
            if (busy_ticks != '0) busy_ticks--;
            if (busy_ticks == '0) begin
                for (c = 0; c < CLASSES; c++) begin
                    if (!found && held[c] != 0) begin
                        entry = waiting_calls[c][head_at[c]];
                        head_at[c] = (head_at[c] + 1) % DEPTH;
                        held[c]--;
                        busy_ticks = entry[DUR_W-1:0];
                        res.answered       = 1'b1;
                        res.answered_id    = entry[ENTRY_W-1:DUR_W];
                        res.answered_class = CLS_W'(c);
                        found = 1'b1;
                    end
                end
            end
        end
        res.line_busy = (busy_ticks != '0);
        res.all_empty = queues_clear();
        return res;
    endfunction

    task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        fcpcs_pkg::t_out_data got;
        fcpcs_pkg::t_out_data want;
        fcpcs_pkg::t_out_data fresh;
        int                   c;
        if (!i_rst_n) begin
            for (c = 0; c < CLASSES; c++) begin
                head_at[c] = 0;
                tail_at[c] = 0;
                held[c]    = 0;
            end
            busy_ticks = '0;
            pending_outcomes.delete();
            o_fail_count    = 0;
            o_request_count = 0;
            o_result_count  = 0;
            o_answer_count  = 0;
            o_drop_count    = 0;
        end else begin
            // a result leaving this edge belongs to a request taken earlier
            if (i_m_tvalid && i_m_tready) begin
                got = fcpcs_pkg::t_out_data'(i_m_tdata);
                o_result_count++;
                if (pending_outcomes.size() == 0) begin
                    $display("%0t: result expected none got %h", $time, i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = pending_outcomes.pop_front();
                    report_field("accepted", 32'(want.accepted), 32'(got.accepted));
                    report_field("dropped", 32'(want.dropped), 32'(got.dropped));
                    report_field("answered", 32'(want.answered), 32'(got.answered));
                    report_field("answered_id", 32'(want.answered_id),
                                 32'(got.answered_id));
                    report_field("answered_class", 32'(want.answered_class),
                                 32'(got.answered_class));
                    report_field("line_busy", 32'(want.line_busy), 32'(got.line_busy));
                    report_field("all_empty", 32'(want.all_empty), 32'(got.all_empty));
                    report_field("pad", 32'(want.pad), 32'(got.pad));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                fresh = serve_request(i_s_tuser[0], fcpcs_pkg::t_in_data'(i_s_tdata));
                pending_outcomes.push_back(fresh);
                o_request_count++;
                if (fresh.answered) o_answer_count++;
                if (fresh.dropped) o_drop_count++;
            end
        end
        o_pending    = pending_outcomes.size();
        o_model_idle = queues_clear() && (busy_ticks == '0);
    end

endmodule

// File: verif/tb_four_class_priority_call_scheduler.sv
// testbench top for the four class priority call scheduler: directed calls, then random traffic
// of mostly arrival bursts closed by a tick, then full queues; checking is left to the checker
// depends on fcpcs_pkg, fcpcs_outcome_checker and the scheduler rtl
`timescale 1ns / 1ps

module tb_four_class_priority_call_scheduler;

    localparam int CLS_W = fcpcs_pkg::CLS_W;
    localparam int ID_W  = fcpcs_pkg::ID_W;
    localparam int DUR_W = fcpcs_pkg::DUR_W;

    // priority classes, highest first
    localparam logic [CLS_W-1:0] CLS_PLATINUM = 2'd0;
    localparam logic [CLS_W-1:0] CLS_GOLD     = 2'd1;
    localparam logic [CLS_W-1:0] CLS_SILVER   = 2'd2;
    localparam logic [CLS_W-1:0] CLS_REGULAR  = 2'd3;

    localparam int RANDOM_REQUESTS = 1300;
    localparam int STALL_CYCLES    = 150;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [1:0] caller_class, [17:2] caller_id, [33:18] call_duration, [39:34] zero
    logic [39:0] s_axis_tdata;
    // [0] action
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [0] accepted, [1] dropped, [2] answered, [18:3] answered_id,
    // [20:19] answered_class, [21] line_busy, [22] all_empty, [23] zero
    logic [23:0] m_axis_tdata;

    int   fail_count;
    int   pending;
    int   request_count;
    int   result_count;
    int   answer_count;
    int   drop_count;
    logic model_idle;

    int   sent = 0;
    // quiet turns off idling on both sides; stall_request asks the receiver for a long hold-off
    logic quiet = 1'b0;
    logic stall_request = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    four_class_priority_call_scheduler uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    fcpcs_outcome_checker outcome_check (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tuser       (s_axis_tuser),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_request_count (request_count),
        .o_result_count  (result_count),
        .o_answer_count  (answer_count),
        .o_drop_count    (drop_count),
        .o_model_idle    (model_idle)
    );

    // offers one request from a falling edge and returns at the falling edge after it is taken;
    // valid stays high into the next request unless an idle cycle is drawn
    task automatic send_request(logic act, logic [CLS_W-1:0] cls, logic [ID_W-1:0] id,
                                logic [DUR_W-1:0] dur);
        fcpcs_pkg::t_in_data req;
        req               = '0;
        req.caller_class  = cls;
        req.caller_id     = id;
        req.call_duration = dur;
        while (!quiet && $urandom_range(99) < 29) begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = req;
        s_axis_tuser  = act;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic arrive(logic [CLS_W-1:0] cls, logic [ID_W-1:0] id, logic [DUR_W-1:0] dur);
        send_request(fcpcs_pkg::ACT_ARRIVE, cls, id, dur);
    endtask

    // tick with random content in the fields it ignores
    task automatic tick();
        send_request(fcpcs_pkg::ACT_TICK, CLS_W'($urandom_range(3)), ID_W'($urandom),
                     DUR_W'($urandom));
    endtask

    // mostly short calls so the line keeps turning over, now and then a longer one
    function automatic logic [DUR_W-1:0] short_duration();
        if ($urandom_range(9) == 0) return DUR_W'($urandom_range(24));
        return DUR_W'($urandom_range(3));
    endfunction

    // receiver: random back-pressure, plus one long hold-off while the sender keeps offering
    initial begin : receiver
        int   hold_left;
        logic stall_taken;
        hold_left     = 0;
        stall_taken   = 1'b0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (stall_request && !stall_taken) begin
                stall_taken = 1'b1;
                hold_left   = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready = 1'b0;
            end else begin
                m_axis_tready = quiet || ($urandom_range(99) >= 29);
            end
        end
    end

    initial begin : stimulus
        int   n_arrive;
        int   pick;
        int   k;
        int   c;
        logic heavy;
        logic stall_done;
        stall_done    = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = fcpcs_pkg::ACT_ARRIVE;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: tick on an empty idle line, counter must stay at zero
        send_request(fcpcs_pkg::ACT_TICK, CLS_PLATINUM, 16'h0000, 16'h0000);
        // one caller per class, extreme ids, arriving lowest priority first
        arrive(CLS_REGULAR, 16'h0000, 16'h0000);
        arrive(CLS_SILVER, 16'hFFFF, 16'h0001);
        arrive(CLS_GOLD, 16'h5A5A, 16'h0002);
        arrive(CLS_PLATINUM, 16'hA5A5, 16'h0000);
        // platinum with zero duration frees the line at once, then gold holds it two ticks
        send_request(fcpcs_pkg::ACT_TICK, CLS_PLATINUM, 16'h0000, 16'h0000);
        send_request(fcpcs_pkg::ACT_TICK, CLS_PLATINUM, 16'h0000, 16'h0000);
        send_request(fcpcs_pkg::ACT_TICK, CLS_PLATINUM, 16'h0000, 16'h0000);
        send_request(fcpcs_pkg::ACT_TICK, CLS_PLATINUM, 16'h0000, 16'h0000);
        send_request(fcpcs_pkg::ACT_TICK, CLS_PLATINUM, 16'h0000, 16'h0000);
        // nothing left to answer
        send_request(fcpcs_pkg::ACT_TICK, CLS_PLATINUM, 16'h0000, 16'h0000);
        // order within a class, and platinum ahead of a later gold arrival
        arrive(CLS_PLATINUM, 16'h1234, 16'h0003);
        arrive(CLS_PLATINUM, 16'h8001, 16'h0000);
        send_request(fcpcs_pkg::ACT_TICK, CLS_PLATINUM, 16'h0000, 16'h0000);
        arrive(CLS_GOLD, 16'h00FF, 16'h0001);
        repeat (5) send_request(fcpcs_pkg::ACT_TICK, CLS_PLATINUM, 16'h0000, 16'h0000);

        // random: mostly a burst of arrivals closed by its tick, some tick runs and
        // arrival floods; load swings between light and heavy phases
        while (sent < RANDOM_REQUESTS) begin
            quiet = (sent >= 700 && sent < 900);
            if (!stall_done && sent >= 400) begin
                stall_request = 1'b1;
                stall_done    = 1'b1;
            end
            heavy = ((sent / 150) % 3 == 1);
            pick  = $urandom_range(99);
            if (pick < 85) begin
                k = $urandom_range(9);
                if (heavy) n_arrive = (k < 2) ? 1 : (k < 6) ? 2 : 3;
                else       n_arrive = (k < 5) ? 0 : (k < 8) ? 1 : 2;
                repeat (n_arrive)
                    arrive(CLS_W'($urandom_range(3)), ID_W'($urandom), short_duration());
                tick();
            end else if (pick < 93) begin
                repeat ($urandom_range(5, 2)) tick();
            end else begin
                repeat ($urandom_range(6, 3))
                    arrive(CLS_W'($urandom_range(3)), ID_W'($urandom), short_duration());
            end
        end
        quiet = 1'b0;

        // drain the queues, then tie the line up with the longest call and overfill every class
        while (!model_idle) tick();
        arrive(CLS_PLATINUM, 16'hFFFF, 16'hFFFF);
        tick();
        for (c = 0; c < fcpcs_pkg::NUM_CLASSES_DEF; c++) begin
            for (k = 0; k <= fcpcs_pkg::QUEUE_DEPTH_DEF; k++) begin
                arrive(CLS_W'(c), ID_W'($urandom), DUR_W'($urandom));
                if (k % 8 == 7) tick();
            end
            // one more on the full class
            arrive(CLS_W'(c), ID_W'($urandom), DUR_W'($urandom));
        end
        s_axis_tvalid = 1'b0;

        // wait for the last results, then let the answer path settle
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);

        $display("summary: %0d requests sent, %0d results checked", request_count, result_count);
        $display("summary: %0d calls answered, %0d arrivals dropped, long output hold-off applied",
                 answer_count, drop_count);
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
